@@ design/assert_macros.svh @@
// Assertion macros shared by the splitter RTL.
// Every user must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define MFS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mfs_pkg.sv @@
// Shared types and constants for the message frame splitter.
// No dependencies; used by every module of the block.
package mfs_pkg;

    localparam int SID_LIMIT   = 64;
    localparam int EVENT_LIMIT = 512;
    localparam int META_LIMIT  = 4096;

    localparam int CNT_W = 13;

    localparam logic [CNT_W-1:0] SID_LAST   = CNT_W'(SID_LIMIT - 1);
    localparam logic [CNT_W-1:0] EVENT_LAST = CNT_W'(EVENT_LIMIT - 1);
    localparam logic [CNT_W-1:0] META_LAST  = CNT_W'(META_LIMIT - 1);

    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    localparam logic [31:0] PING_RESET = 32'd1;
    localparam logic [31:0] PONG_RESET = 32'd2;

    // register indexes of the configuration port
    localparam logic REG_PING = 1'b0;
    localparam logic REG_PONG = 1'b1;

    typedef enum logic [2:0] {
        TAG_LENGTH  = 3'd0,
        TAG_FLAG    = 3'd1,
        TAG_SID     = 3'd2,
        TAG_EVENT   = 3'd3,
        TAG_META    = 3'd4,
        TAG_DATA    = 3'd5,
        TAG_IGNORED = 3'd6
    } t_tag;

    typedef struct packed {
        logic [31:0] ping;
        logic [31:0] pong;
    } t_codes;

    typedef struct packed {
        logic [7:0]  data;
        t_tag        tag;
        logic        delim;
        logic [31:0] flag;
        logic        flag_valid;
        logic        heartbeat;
        logic        overrun;
        logic        last;
    } t_result;

    // last count value before a field hits its search limit
    function automatic logic [CNT_W-1:0] limit_last(input logic [1:0] fidx);
        logic [CNT_W-1:0] v;
        case (fidx)
            2'd0:    v = SID_LAST;
            2'd1:    v = EVENT_LAST;
            default: v = META_LAST;
        endcase
        return v;
    endfunction

endpackage

@@ design/message_frame_splitter.sv @@
// Top level of the message frame splitter: input register, tagger, result register.
// Depends on mfs_pkg, mfs_cfg_regs and mfs_tagger.
//
//  channel  | direction | tdata                          | tuser          | tlast
//  s        | in        | in_byte                        | -              | last_byte
//  m        | out       | out_byte..overrun (see port)   | tag, delimiter | end_of_frame
//  cfg      | in        | write: index 0 ping, 1 pong    | -              | -
//
// One request per cycle sustained while m does not stall; an accepted byte passes from the
// input register through the tagger into the result register.
// Parse state advances when a byte moves from input to result register.
// A stall on m holds both registers; s stays ready while the input register is free.
// Reset clears parse state and loads ping 1, pong 2; no clearing pass.
module message_frame_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] out_byte, [39:8] flag_value,
                                          // [40] flag_valid, [41] is_heartbeat,
                                          // [42] overrun, [47:43] zero
    output logic [3:0]  o_m_axis_tuser,   // [2:0] field_tag, [3] is_delimiter
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_out_valid;
    mfs_pkg::t_result   r_out;
    mfs_pkg::t_result   res;
    mfs_pkg::t_codes    codes;
    logic               advance;
    logic               take;
    logic               accept;

    assign advance = !r_out_valid || i_m_axis_tready;
    assign take    = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;

    mfs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_codes (codes)
    );

    mfs_tagger u_tagger (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (take),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_codes (codes),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.overrun, r_out.heartbeat, r_out.flag_valid,
                              r_out.flag, r_out.data};
    assign o_m_axis_tuser  = {r_out.delim, r_out.tag};
    assign o_m_axis_tlast  = r_out.last;

endmodule

@@ design/mfs_cfg_regs.sv @@
// Ping/pong code registers of the splitter.
// Depends on mfs_pkg.
module mfs_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic                i_idx,
    input  logic [31:0]         i_data,
    output mfs_pkg::t_codes     o_codes
);

    logic [31:0] r_ping;
    logic [31:0] r_pong;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping <= mfs_pkg::PING_RESET;
            r_pong <= mfs_pkg::PONG_RESET;
        end else if (i_we) begin
            unique case (i_idx)
                mfs_pkg::REG_PING: r_ping <= i_data;
                mfs_pkg::REG_PONG: r_pong <= i_data;
                default: ;
            endcase
        end
    end

    assign o_codes.ping = r_ping;
    assign o_codes.pong = r_pong;

endmodule

@@ design/mfs_tagger.sv @@
// Per-frame parse state and byte tagging logic.
// Depends on mfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfs_tagger (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  mfs_pkg::t_codes     i_codes,
    output mfs_pkg::t_result    o_res
);

    logic [3:0]                 r_hc, n_hc;
    logic [1:0]                 r_fidx, n_fidx;
    logic [mfs_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_nl, n_nl;
    logic [31:0]                r_flag, n_flag;
    logic                       r_hb, n_hb;
    logic                       r_ovr, n_ovr;
    mfs_pkg::t_tag              tag;
    logic                       delim;

    always_comb begin
        n_hc   = r_hc;
        n_fidx = r_fidx;
        n_cnt  = r_cnt;
        n_nl   = r_nl;
        n_flag = r_flag;
        n_hb   = r_hb;
        n_ovr  = r_ovr;
        tag    = mfs_pkg::TAG_IGNORED;
        delim  = 1'b0;
        if (!r_hc[3] && !r_hc[2]) begin
            tag  = mfs_pkg::TAG_LENGTH;
            n_hc = r_hc + 4'd1;
        end else if (!r_hc[3]) begin
            tag    = mfs_pkg::TAG_FLAG;
            n_flag = {r_flag[23:0], i_byte};
            n_hc   = r_hc + 4'd1;
            if (n_hc[3])
                n_hb = (n_flag == i_codes.ping) || (n_flag == i_codes.pong);
        end else if (r_hb) begin
            tag = mfs_pkg::TAG_IGNORED;
        end else if (r_nl && i_byte == mfs_pkg::BYTE_LF) begin
            // newline after a zero still belongs to the field just closed
            n_nl  = 1'b0;
            tag   = mfs_pkg::t_tag'(3'(mfs_pkg::TAG_SID) + 3'(r_fidx) - 3'd1);
            delim = 1'b1;
        end else begin
            n_nl = 1'b0;
            if (r_fidx == 2'd3) begin
                tag = mfs_pkg::TAG_DATA;
            end else begin
                tag = mfs_pkg::t_tag'(3'(mfs_pkg::TAG_SID) + 3'(r_fidx));
                if (i_byte == mfs_pkg::BYTE_NUL) begin
                    delim  = 1'b1;
                    n_nl   = 1'b1;
                    n_fidx = r_fidx + 2'd1;
                    n_cnt  = '0;
                end else if (r_cnt >= mfs_pkg::limit_last(r_fidx)) begin
                    n_ovr  = 1'b1;
                    n_fidx = r_fidx + 2'd1;
                    n_cnt  = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_hc   <= '0;
            r_fidx <= '0;
            r_cnt  <= '0;
            r_nl   <= 1'b0;
            r_flag <= '0;
            r_hb   <= 1'b0;
            r_ovr  <= 1'b0;
        end else if (i_step) begin
            r_hc   <= n_hc;
            r_fidx <= n_fidx;
            r_cnt  <= n_cnt;
            r_nl   <= n_nl;
            r_flag <= n_flag;
            r_hb   <= n_hb;
            r_ovr  <= n_ovr;
        end
    end

    assign o_res.data       = i_byte;
    assign o_res.tag        = tag;
    assign o_res.delim      = delim;
    assign o_res.flag       = n_flag;
    assign o_res.flag_valid = n_hc[3];
    assign o_res.heartbeat  = n_hb;
    assign o_res.overrun    = n_ovr;
    assign o_res.last       = i_last;

    `MFS_ASSERT_SAME(a_delim_in_field, o_res.delim,
        o_res.tag == mfs_pkg::TAG_SID || o_res.tag == mfs_pkg::TAG_EVENT ||
        o_res.tag == mfs_pkg::TAG_META, "delimiter outside sid/event/meta")
    `MFS_ASSERT_NEXT(a_frame_clear, i_step && i_last,
        r_hc == 4'd0 && r_fidx == 2'd0 && !r_ovr, "state not cleared after last byte")
    `MFS_ASSERT_SAME(a_hb_after_flag, r_hb, r_hc == 4'd8, "heartbeat before flag complete")
    `MFS_ASSERT_SAME(a_ovr_moves_field, r_ovr, r_fidx != 2'd0, "overrun without field advance")

endmodule
